/* rtl/core/deep_depth_band_flatten_macros.svh */
// Assertion macros shared by the deep flatten RTL.
`ifndef DEEP_DEPTH_BAND_FLATTEN_MACROS_SVH
`define DEEP_DEPTH_BAND_FLATTEN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DBF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DBF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dbf_pkg.sv */
// Shared constants, widths and arithmetic helpers for the deep flatten block.
`timescale 1ns / 1ps

package dbf_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;

    localparam int COL_IN_W  = 16;
    localparam int COL_ACC_W = 24;
    localparam int ALPHA_W   = 13;
    localparam int DEPTH_W   = 32;
    localparam int BAND_W    = 31;
    localparam int CHAN_W    = 5;
    localparam int CNT_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SCALED_W  = 17;

    localparam logic [ALPHA_W-1:0] ONE_Q12 = 13'd4096;
    localparam logic signed [COL_ACC_W-1:0] COL_MAX = 24'sh7FFFFF;
    localparam logic signed [COL_ACC_W-1:0] COL_MIN = 24'sh800000;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 5'h1F;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DEPTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_DEPTH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_PRESENT = 2'd2;

    // channel_present bits
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;
    localparam int CH_Z = 4;

    // round(s * w / 4096), half toward plus infinity
    function automatic logic signed [SCALED_W-1:0] scale_q12(
        input logic signed [COL_IN_W-1:0] s,
        input logic [ALPHA_W-1:0] w
    );
        logic signed [29:0] p;
        p = s * $signed({1'b0, w});
        p = p + 30'sd2048;
        return p[28:12];
    endfunction

    // accumulator plus contribution, clipped to the 24-bit signed range
    function automatic logic signed [COL_ACC_W-1:0] sat_add(
        input logic signed [COL_ACC_W-1:0] acc,
        input logic signed [SCALED_W-1:0] d
    );
        logic signed [COL_ACC_W:0] sum;
        sum = {acc[COL_ACC_W-1], acc} + {{(COL_ACC_W+1-SCALED_W){d[SCALED_W-1]}}, d};
        if (sum[COL_ACC_W] != sum[COL_ACC_W-1]) begin
            return sum[COL_ACC_W] ? COL_MIN : COL_MAX;
        end
        return sum[COL_ACC_W-1:0];
    endfunction

endpackage

/* rtl/core/deep_depth_band_flatten.sv */
// Depth-band deep flatten: front-to-back over compositing of one pixel's samples.
//
// Usage:
//   s_* channel carries one deep sample per request (RGBA Q3.12, depth Q16.16)
//   plus empty_pixel / last_sample flags. m_* channel returns one flattened
//   pixel (RGBA, used count) per last or empty request; other requests
//   return nothing. cfg_* channel writes near_depth (0), far_depth (1) and
//   channel_present (2); write only while no pixel is in flight.
// Path: an accepted request passes the input register, then the result
//   register, before its result shows on m_*.
// Throughput: one sample per cycle while no emitting request stalls; the
//   accumulators loop back through a 16x13 multiply and a 24-bit saturating add.
// Stalls: the input register holds a request that must emit while the
//   result register is still occupied; non-emitting samples keep flowing.
//   s_ready drops only when the input register holds such a request.
// Reset: synchronous, active low; clears the accumulators, both valid
//   flags and the registers to near 0, far 0 (no limit), all channels present.
`timescale 1ns / 1ps
`include "deep_depth_band_flatten_macros.svh"

module deep_depth_band_flatten #(
    parameter int MAX_SAMPLES = dbf_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dbf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dbf_pkg::BAND_W-1:0]            cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [dbf_pkg::COL_IN_W-1:0]   s_sample_red,
    input  logic signed [dbf_pkg::COL_IN_W-1:0]   s_sample_green,
    input  logic signed [dbf_pkg::COL_IN_W-1:0]   s_sample_blue,
    input  logic signed [dbf_pkg::COL_IN_W-1:0]   s_sample_alpha,
    input  logic signed [dbf_pkg::DEPTH_W-1:0]    s_sample_depth,
    input  logic                                  s_empty_pixel,
    input  logic                                  s_last_sample,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [dbf_pkg::COL_ACC_W-1:0]  m_out_red,
    output logic signed [dbf_pkg::COL_ACC_W-1:0]  m_out_green,
    output logic signed [dbf_pkg::COL_ACC_W-1:0]  m_out_blue,
    output logic [dbf_pkg::ALPHA_W-1:0]           m_out_alpha,
    output logic [dbf_pkg::CNT_W-1:0]             m_used_count
);

    localparam int CntCap = (MAX_SAMPLES < 2047) ? MAX_SAMPLES : 2047;
    localparam logic [dbf_pkg::CNT_W-1:0] CntCapV = dbf_pkg::CNT_W'(CntCap);

    // configuration
    logic [dbf_pkg::BAND_W-1:0] near_reg;
    logic [dbf_pkg::BAND_W-1:0] far_reg;
    logic [dbf_pkg::CHAN_W-1:0] chan_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg <= '0;
            far_reg  <= '0;
            chan_reg <= dbf_pkg::CHAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dbf_pkg::CFG_NEAR_DEPTH:      near_reg <= cfg_data;
                dbf_pkg::CFG_FAR_DEPTH:       far_reg  <= cfg_data;
                dbf_pkg::CFG_CHANNEL_PRESENT: chan_reg <= cfg_data[dbf_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic                                 in_valid_reg;
    logic signed [dbf_pkg::COL_IN_W-1:0]  in_red_reg;
    logic signed [dbf_pkg::COL_IN_W-1:0]  in_green_reg;
    logic signed [dbf_pkg::COL_IN_W-1:0]  in_blue_reg;
    logic signed [dbf_pkg::COL_IN_W-1:0]  in_alpha_reg;
    logic signed [dbf_pkg::DEPTH_W-1:0]   in_depth_reg;
    logic                                 in_empty_reg;
    logic                                 in_last_reg;

    // pixel accumulators
    logic signed [dbf_pkg::COL_ACC_W-1:0] acc_red_reg;
    logic signed [dbf_pkg::COL_ACC_W-1:0] acc_green_reg;
    logic signed [dbf_pkg::COL_ACC_W-1:0] acc_blue_reg;
    logic [dbf_pkg::ALPHA_W-1:0]          acc_alpha_reg;
    logic                                 opaque_reg;
    logic [dbf_pkg::CNT_W-1:0]            kept_count_reg;

    // result register
    logic                                 out_valid_reg;
    logic signed [dbf_pkg::COL_ACC_W-1:0] out_red_reg;
    logic signed [dbf_pkg::COL_ACC_W-1:0] out_green_reg;
    logic signed [dbf_pkg::COL_ACC_W-1:0] out_blue_reg;
    logic [dbf_pkg::ALPHA_W-1:0]          out_alpha_reg;
    logic [dbf_pkg::CNT_W-1:0]            out_count_reg;

    logic emits;
    logic out_free;
    logic in_go;

    assign emits    = in_empty_reg || in_last_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign in_go    = in_valid_reg && (!emits || out_free);
    assign s_ready  = !in_valid_reg || in_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_red_reg   <= s_sample_red;
            in_green_reg <= s_sample_green;
            in_blue_reg  <= s_sample_blue;
            in_alpha_reg <= s_sample_alpha;
            in_depth_reg <= s_sample_depth;
            in_empty_reg <= s_empty_pixel;
            in_last_reg  <= s_last_sample;
        end
    end

    // band test and compositing
    logic                                 in_band;
    logic                                 keep;
    logic signed [dbf_pkg::COL_IN_W-1:0]  r_s;
    logic signed [dbf_pkg::COL_IN_W-1:0]  g_s;
    logic signed [dbf_pkg::COL_IN_W-1:0]  b_s;
    logic [dbf_pkg::ALPHA_W-1:0]          a_clamp;
    logic [dbf_pkg::ALPHA_W-1:0]          weight;
    logic signed [dbf_pkg::SCALED_W-1:0]  a_scaled;
    logic [dbf_pkg::ALPHA_W:0]            alpha_sum;

    logic signed [dbf_pkg::COL_ACC_W-1:0] acc_red_next;
    logic signed [dbf_pkg::COL_ACC_W-1:0] acc_green_next;
    logic signed [dbf_pkg::COL_ACC_W-1:0] acc_blue_next;
    logic [dbf_pkg::ALPHA_W-1:0]          acc_alpha_next;
    logic                                 opaque_next;
    logic [dbf_pkg::CNT_W-1:0]            kept_count_next;

    always_comb begin
        in_band = 1'b1;
        if (chan_reg[dbf_pkg::CH_Z]) begin
            // near/far are non-negative, so a zero-extended signed compare is exact
            if (in_depth_reg < $signed({1'b0, near_reg})) begin
                in_band = 1'b0;
            end
            if ((far_reg != '0) && (in_depth_reg > $signed({1'b0, far_reg}))) begin
                in_band = 1'b0;
            end
        end
        keep = !opaque_reg && in_band;

        r_s = chan_reg[dbf_pkg::CH_R] ? in_red_reg   : '0;
        g_s = chan_reg[dbf_pkg::CH_G] ? in_green_reg : '0;
        b_s = chan_reg[dbf_pkg::CH_B] ? in_blue_reg  : '0;
        if (!chan_reg[dbf_pkg::CH_A]) begin
            a_clamp = dbf_pkg::ONE_Q12;
        end else if (in_alpha_reg[dbf_pkg::COL_IN_W-1]) begin
            a_clamp = '0;
        end else if (in_alpha_reg > $signed({3'b000, dbf_pkg::ONE_Q12})) begin
            a_clamp = dbf_pkg::ONE_Q12;
        end else begin
            a_clamp = in_alpha_reg[dbf_pkg::ALPHA_W-1:0];
        end

        weight    = dbf_pkg::ONE_Q12 - acc_alpha_reg;
        a_scaled  = dbf_pkg::scale_q12($signed({3'b000, a_clamp}), weight);
        alpha_sum = {1'b0, acc_alpha_reg} + a_scaled[dbf_pkg::ALPHA_W:0];

        acc_red_next    = acc_red_reg;
        acc_green_next  = acc_green_reg;
        acc_blue_next   = acc_blue_reg;
        acc_alpha_next  = acc_alpha_reg;
        opaque_next     = opaque_reg;
        kept_count_next = kept_count_reg;

        if (keep) begin
            acc_red_next   = dbf_pkg::sat_add(acc_red_reg,
                                 dbf_pkg::scale_q12(r_s, weight));
            acc_green_next = dbf_pkg::sat_add(acc_green_reg,
                                 dbf_pkg::scale_q12(g_s, weight));
            acc_blue_next  = dbf_pkg::sat_add(acc_blue_reg,
                                 dbf_pkg::scale_q12(b_s, weight));
            if (kept_count_reg < CntCapV) begin
                kept_count_next = kept_count_reg + 1'b1;
            end
            if (alpha_sum >= {1'b0, dbf_pkg::ONE_Q12}) begin
                acc_alpha_next = dbf_pkg::ONE_Q12;
                opaque_next    = 1'b1;
            end else begin
                acc_alpha_next = alpha_sum[dbf_pkg::ALPHA_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_red_reg    <= '0;
            acc_green_reg  <= '0;
            acc_blue_reg   <= '0;
            acc_alpha_reg  <= '0;
            opaque_reg     <= 1'b0;
            kept_count_reg <= '0;
        end else if (in_go) begin
            if (emits) begin
                // pixel done: start clean for the next one
                acc_red_reg    <= '0;
                acc_green_reg  <= '0;
                acc_blue_reg   <= '0;
                acc_alpha_reg  <= '0;
                opaque_reg     <= 1'b0;
                kept_count_reg <= '0;
            end else begin
                acc_red_reg    <= acc_red_next;
                acc_green_reg  <= acc_green_next;
                acc_blue_reg   <= acc_blue_next;
                acc_alpha_reg  <= acc_alpha_next;
                opaque_reg     <= opaque_next;
                kept_count_reg <= kept_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_go && emits) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_go && emits) begin
            if (in_empty_reg) begin
                out_red_reg   <= '0;
                out_green_reg <= '0;
                out_blue_reg  <= '0;
                out_alpha_reg <= '0;
                out_count_reg <= '0;
            end else begin
                out_red_reg   <= acc_red_next;
                out_green_reg <= acc_green_next;
                out_blue_reg  <= acc_blue_next;
                out_alpha_reg <= acc_alpha_next;
                out_count_reg <= kept_count_next;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_red    = out_red_reg;
    assign m_out_green  = out_green_reg;
    assign m_out_blue   = out_blue_reg;
    assign m_out_alpha  = out_alpha_reg;
    assign m_used_count = out_count_reg;

    `DBF_ASSERT_NOW(a_opaque_pins_alpha, aclk, aresetn,
        opaque_reg, acc_alpha_reg == dbf_pkg::ONE_Q12, "opaque set but alpha not one")

    `DBF_ASSERT_NOW(a_no_count_no_alpha, aclk, aresetn,
        kept_count_reg == '0, acc_alpha_reg == '0, "alpha accumulated without a kept sample")

    `DBF_ASSERT_NEXT(a_emit_clears_pixel, aclk, aresetn,
        in_go && emits, (acc_alpha_reg == '0) && (kept_count_reg == '0) && !opaque_reg &&
        out_valid_reg, "pixel state not cleared or result missing after emit")

endmodule

/* bench/tb_deep_depth_band_flatten.sv */
`timescale 1ns / 1ps
// Self-checking bench for the depth-band deep flatten: directed rows, random pixels, predictor.
module tb_deep_depth_band_flatten;

    localparam int COUNT_CAP = (dbf_pkg::MAX_SAMPLES_DEF < 2047) ?
                               dbf_pkg::MAX_SAMPLES_DEF : 2047;
    localparam int ONE = 4096;
    localparam int TOTAL_ITEMS = 1650;
    localparam int PHASE_ITEMS = 60;
    localparam int LONG_PIXEL = COUNT_CAP + 12;
    localparam logic [dbf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic signed [dbf_pkg::COL_IN_W-1:0] red;
        logic signed [dbf_pkg::COL_IN_W-1:0] green;
        logic signed [dbf_pkg::COL_IN_W-1:0] blue;
        logic signed [dbf_pkg::COL_IN_W-1:0] alpha;
        logic signed [dbf_pkg::DEPTH_W-1:0]  depth;
        bit                                  empty;
        bit                                  last;
    } sample_t;

    typedef struct {
        logic signed [dbf_pkg::COL_ACC_W-1:0] red;
        logic signed [dbf_pkg::COL_ACC_W-1:0] green;
        logic signed [dbf_pkg::COL_ACC_W-1:0] blue;
        logic [dbf_pkg::ALPHA_W-1:0]          alpha;
        logic [dbf_pkg::CNT_W-1:0]            count;
    } pixel_t;

    typedef struct {
        bit                            is_reg;
        logic [dbf_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [dbf_pkg::BAND_W-1:0]    reg_val;
        sample_t                       smp;
        bit                            typed;
        pixel_t                        want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [dbf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dbf_pkg::BAND_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [dbf_pkg::COL_IN_W-1:0] s_sample_red;
    logic signed [dbf_pkg::COL_IN_W-1:0] s_sample_green;
    logic signed [dbf_pkg::COL_IN_W-1:0] s_sample_blue;
    logic signed [dbf_pkg::COL_IN_W-1:0] s_sample_alpha;
    logic signed [dbf_pkg::DEPTH_W-1:0] s_sample_depth;
    logic s_empty_pixel;
    logic s_last_sample;
    logic m_valid;
    logic m_ready;
    logic signed [dbf_pkg::COL_ACC_W-1:0] m_out_red;
    logic signed [dbf_pkg::COL_ACC_W-1:0] m_out_green;
    logic signed [dbf_pkg::COL_ACC_W-1:0] m_out_blue;
    logic [dbf_pkg::ALPHA_W-1:0] m_out_alpha;
    logic [dbf_pkg::CNT_W-1:0] m_used_count;

    // flattener model state and its copy of the registers
    longint acc_red, acc_green, acc_blue, acc_alpha;
    bit opaque;
    int kept;
    logic [dbf_pkg::BAND_W-1:0] band_near, band_far;
    logic [dbf_pkg::CHAN_W-1:0] chan_mask;

    pixel_t pending_pixels[$];
    row_t script[$];
    int fails = 0;
    int accepted = 0;
    int results_seen = 0;
    int sent_items = 0;
    int settings_used = 0;
    bit steady = 1'b0;
    int ready_hold = 0;

    // typed-in expectation travelling with the request on the bus
    bit cur_typed;
    pixel_t cur_known;

    sample_t seen_sample;
    pixel_t folded, want_px;
    bit emits;

    deep_depth_band_flatten dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_red   (s_sample_red),
        .s_sample_green (s_sample_green),
        .s_sample_blue  (s_sample_blue),
        .s_sample_alpha (s_sample_alpha),
        .s_sample_depth (s_sample_depth),
        .s_empty_pixel  (s_empty_pixel),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_out_alpha    (m_out_alpha),
        .m_used_count   (m_used_count)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic longint over_term(longint s, longint w);
        return (s * w + 2048) >>> 12;   // floor after adding half: rounds half up
    endfunction

    function automatic longint clip_colour(longint v);
        if (v > longint'(dbf_pkg::COL_MAX)) return longint'(dbf_pkg::COL_MAX);
        if (v < longint'(dbf_pkg::COL_MIN)) return longint'(dbf_pkg::COL_MIN);
        return v;
    endfunction

    task automatic restart_pixel();
        acc_red = 0;
        acc_green = 0;
        acc_blue = 0;
        acc_alpha = 0;
        opaque = 1'b0;
        kept = 0;
    endtask

    task automatic fold_sample(input sample_t s, output bit emit, output pixel_t px);
        longint z, w, r, g, b, a;
        bit keep;
        emit = 1'b0;
        px = '{default: '0};
        if (s.empty) begin
            emit = 1'b1;
            restart_pixel();
        end else begin
            if (!opaque) begin
                keep = 1'b1;
                if (chan_mask[dbf_pkg::CH_Z]) begin
                    z = s.depth;
                    if (z < longint'(band_near)) keep = 1'b0;
                    if (band_far != 0 && z > longint'(band_far)) keep = 1'b0;
                end
                if (keep) begin
                    r = chan_mask[dbf_pkg::CH_R] ? s.red : 0;
                    g = chan_mask[dbf_pkg::CH_G] ? s.green : 0;
                    b = chan_mask[dbf_pkg::CH_B] ? s.blue : 0;
                    a = chan_mask[dbf_pkg::CH_A] ? s.alpha : ONE;
                    if (a < 0) a = 0;
                    if (a > ONE) a = ONE;
                    w = ONE - acc_alpha;
                    acc_red = clip_colour(acc_red + over_term(r, w));
                    acc_green = clip_colour(acc_green + over_term(g, w));
                    acc_blue = clip_colour(acc_blue + over_term(b, w));
                    acc_alpha += over_term(a, w);
                    if (kept < COUNT_CAP) kept++;
                    if (acc_alpha >= ONE) begin
                        acc_alpha = ONE;
                        opaque = 1'b1;
                    end
                end
            end
            if (s.last) begin
                emit = 1'b1;
                px.red = dbf_pkg::COL_ACC_W'(acc_red);
                px.green = dbf_pkg::COL_ACC_W'(acc_green);
                px.blue = dbf_pkg::COL_ACC_W'(acc_blue);
                px.alpha = dbf_pkg::ALPHA_W'(acc_alpha);
                px.count = dbf_pkg::CNT_W'(kept);
                restart_pixel();
            end
        end
    endtask

    // ---------------- monitor and scoreboard ----------------

    task automatic match_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dbf_pkg::CFG_NEAR_DEPTH:      band_near = cfg_data;
                    dbf_pkg::CFG_FAR_DEPTH:       band_far = cfg_data;
                    dbf_pkg::CFG_CHANNEL_PRESENT: chan_mask = cfg_data[dbf_pkg::CHAN_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel result with none pending: red %0d alpha %0d count %0d",
                           m_out_red, m_out_alpha, m_used_count);
                    fails++;
                end else begin
                    want_px = pending_pixels.pop_front();
                    match_field("out_red", want_px.red, m_out_red);
                    match_field("out_green", want_px.green, m_out_green);
                    match_field("out_blue", want_px.blue, m_out_blue);
                    match_field("out_alpha", want_px.alpha, m_out_alpha);
                    match_field("used_count", want_px.count, m_used_count);
                    results_seen++;
                end
            end
            if (s_valid && s_ready) begin
                seen_sample.red = s_sample_red;
                seen_sample.green = s_sample_green;
                seen_sample.blue = s_sample_blue;
                seen_sample.alpha = s_sample_alpha;
                seen_sample.depth = s_sample_depth;
                seen_sample.empty = s_empty_pixel;
                seen_sample.last = s_last_sample;
                fold_sample(seen_sample, emits, folded);
                if (emits) begin
                    pending_pixels.insert(pending_pixels.size(),
                                          cur_typed ? cur_known : folded);
                end
                accepted++;
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_ready && !steady && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            ready_hold <= idle_len();
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_sample(input sample_t s, input bit typed, input pixel_t want);
        s_valid <= 1'b1;
        s_sample_red <= s.red;
        s_sample_green <= s.green;
        s_sample_blue <= s.blue;
        s_sample_alpha <= s.alpha;
        s_sample_depth <= s.depth;
        s_empty_pixel <= s.empty;
        s_last_sample <= s.last;
        cur_typed <= typed;
        cur_known <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic pause_after();
        int g;
        g = idle_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // drain all pending pixels, then let the pipeline empty; the first edge
    // makes sure the request accepted just now is already queued
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [dbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbf_pkg::BAND_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_band(input logic [dbf_pkg::BAND_W-1:0] nr,
                              input logic [dbf_pkg::BAND_W-1:0] fr,
                              input logic [dbf_pkg::CHAN_W-1:0] ch);
        write_reg(dbf_pkg::CFG_NEAR_DEPTH, nr);
        write_reg(dbf_pkg::CFG_FAR_DEPTH, fr);
        write_reg(dbf_pkg::CFG_CHANNEL_PRESENT, dbf_pkg::BAND_W'(ch));
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, dbf_pkg::BAND_W'($urandom));
        settings_used++;
    endtask

    function automatic logic signed [dbf_pkg::COL_IN_W-1:0] colour_pick();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return dbf_pkg::COL_IN_W'($urandom);
        endcase
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        longint d;
        s.red = colour_pick();
        s.green = colour_pick();
        s.blue = colour_pick();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: s.alpha = dbf_pkg::COL_IN_W'($urandom_range(0, 800));
            5: s.alpha = dbf_pkg::COL_IN_W'(ONE);
            6: s.alpha = dbf_pkg::COL_IN_W'($urandom_range(ONE + 1, 32767));
            7: s.alpha = dbf_pkg::COL_IN_W'($urandom) | 16'h8000;
            default: s.alpha = dbf_pkg::COL_IN_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1: d = $urandom;
            2: d = longint'(band_near) + $urandom_range(0, 4) - 2;
            3: d = longint'(band_far) + $urandom_range(0, 4) - 2;
            4: d = -longint'($urandom_range(1, 32'h7FFFFFFF));
            default: begin
                if (band_far != 0 && band_far >= band_near)
                    d = longint'(band_near) + $urandom_range(0, band_far - band_near);
                else
                    d = longint'(band_near) + $urandom_range(0, 32'hFFFFF);
            end
        endcase
        s.depth = dbf_pkg::DEPTH_W'(d);
        s.empty = 1'b0;
        s.last = 1'b0;
        return s;
    endfunction

    function automatic int pixel_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) return 0;
        if (r < 16) return $urandom_range(1, 6);
        if (r < 19) return $urandom_range(7, 16);
        return $urandom_range(17, 48);
    endfunction

    // zero length sends a lone empty-pixel request; otherwise an empty request
    // may break the pixel midway
    task automatic send_pixel(input int len);
        sample_t s;
        pixel_t none;
        int i;
        none = '{default: '0};
        for (i = 0; i < (len == 0 ? 1 : len); i++) begin
            s = random_sample();
            s.last = (i == len - 1);
            s.empty = (len == 0) || (i < len - 1 && $urandom_range(0, 24) == 0);
            if (s.empty) s.last = $urandom_range(0, 1);
            send_sample(s, 1'b0, none);
            pause_after();
        end
    endtask

    function automatic row_t reg_row(input logic [dbf_pkg::CFG_IDX_W-1:0] idx,
                                     input longint val);
        row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = dbf_pkg::BAND_W'(val);
        return row;
    endfunction

    function automatic row_t smp_row(input int r, g, b, a, input longint z, input bit e, l);
        row_t row;
        row = '{default: '0};
        row.smp.red = dbf_pkg::COL_IN_W'(r);
        row.smp.green = dbf_pkg::COL_IN_W'(g);
        row.smp.blue = dbf_pkg::COL_IN_W'(b);
        row.smp.alpha = dbf_pkg::COL_IN_W'(a);
        row.smp.depth = dbf_pkg::DEPTH_W'(z);
        row.smp.empty = e;
        row.smp.last = l;
        return row;
    endfunction

    function automatic row_t known_row(input int r, g, b, a, input longint z, input bit e, l,
                                       input int er, eg, eb, ea, ec);
        row_t row;
        row = smp_row(r, g, b, a, z, e, l);
        row.typed = 1'b1;
        row.want.red = dbf_pkg::COL_ACC_W'(er);
        row.want.green = dbf_pkg::COL_ACC_W'(eg);
        row.want.blue = dbf_pkg::COL_ACC_W'(eb);
        row.want.alpha = dbf_pkg::ALPHA_W'(ea);
        row.want.count = dbf_pkg::CNT_W'(ec);
        return row;
    endfunction

    function automatic void add_row(input row_t row);
        script.insert(script.size(), row);
    endfunction

    initial begin
        int k;
        int phase_start;
        int i;
        logic [dbf_pkg::BAND_W-1:0] nr, fr;
        logic [dbf_pkg::CHAN_W-1:0] ch;
        sample_t s;
        pixel_t none;

        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_sample_red = '0;
        s_sample_green = '0;
        s_sample_blue = '0;
        s_sample_alpha = '0;
        s_sample_depth = '0;
        s_empty_pixel = 1'b0;
        s_last_sample = 1'b0;
        m_ready = 1'b0;
        cur_typed = 1'b0;
        cur_known = '{default: '0};
        none = '{default: '0};
        band_near = '0;
        band_far = '0;
        chan_mask = dbf_pkg::CHAN_RESET;
        restart_pixel();

        // red green blue alpha depth empty last -> red green blue alpha count
        add_row(known_row(9, 9, 9, 9, 0, 1, 0, 0, 0, 0, 0, 0));
        add_row(known_row(4096, 0, -4096, 4096, 0, 0, 1, 4096, 0, -4096, 4096, 1));
        add_row(known_row(32767, -32768, 32767, 32767, 32'h7FFFFFFF, 0, 1,
                          32767, -32768, 32767, 4096, 1));
        add_row(smp_row(100, 0, 0, -32768, 32'h10000, 0, 0));  // alpha clamps to 0
        add_row(smp_row(4096, -3, 3, 2048, 0, 0, 1));
        add_row(smp_row(0, 0, 0, 2048, 0, 0, 0));
        add_row(smp_row(3, -3, 1, 2048, 0, 0, 1));             // half-way rounding
        add_row(known_row(5, 5, 5, 100, -1, 0, 1, 0, 0, 0, 0, 0));
        add_row(smp_row(1, 0, 0, 4096, 0, 0, 0));              // goes opaque
        add_row(known_row(5000, 7, 7, 4096, 0, 0, 1, 1, 0, 0, 4096, 1));
        add_row(smp_row(300, 300, 300, 10, 0, 0, 0));
        add_row(known_row(1, 1, 1, 1, 0, 1, 1, 0, 0, 0, 0, 0)); // empty beats last
        add_row(reg_row(dbf_pkg::CFG_NEAR_DEPTH, 32'h10000));
        add_row(reg_row(dbf_pkg::CFG_FAR_DEPTH, 32'h20000));
        add_row(smp_row(1, 0, 0, 0, 32'hFFFF, 0, 0));
        add_row(smp_row(1, 0, 0, 0, 32'h10000, 0, 0));
        add_row(smp_row(1, 0, 0, 0, 32'h20000, 0, 0));
        add_row(known_row(1, 0, 0, 0, 32'h20001, 0, 1, 2, 0, 0, 0, 2));
        add_row(reg_row(dbf_pkg::CFG_NEAR_DEPTH, 32'h30000));   // near above far
        add_row(known_row(50, 50, 50, 50, 32'h25000, 0, 1, 0, 0, 0, 0, 0));
        add_row(reg_row(dbf_pkg::CFG_CHANNEL_PRESENT, 0));
        add_row(known_row(777, -5, 9, -5, -64'sd2147483648, 0, 1, 0, 0, 0, 4096, 1));
        add_row(reg_row(CFG_SPARE, 32'h7FFFFFFF));
        add_row(reg_row(dbf_pkg::CFG_CHANNEL_PRESENT, dbf_pkg::CHAN_RESET));
        add_row(reg_row(dbf_pkg::CFG_NEAR_DEPTH, 0));
        add_row(reg_row(dbf_pkg::CFG_FAR_DEPTH, 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[n]) begin
            if (script[n].is_reg) begin
                settle();
                write_reg(script[n].reg_idx, script[n].reg_val);
            end else begin
                send_sample(script[n].smp, script[n].typed, script[n].want);
                pause_after();
            end
        end

        k = 0;
        while (sent_items < TOTAL_ITEMS) begin
            steady = (k % 4 == 3);
            settle();
            if (k == 2) begin
                // one deep pixel: never opaque, so the count hits its bound
                // and the color sums clip both ways
                apply_band(0, 0, dbf_pkg::CHAN_RESET);
                for (i = 0; i < LONG_PIXEL; i++) begin
                    s = random_sample();
                    s.red = dbf_pkg::COL_IN_W'($urandom_range(16384, 32767));
                    s.green = dbf_pkg::COL_IN_W'($urandom) | 16'h8000;
                    s.alpha = $urandom_range(0, 1) ? '0 :
                              (dbf_pkg::COL_IN_W'($urandom) | 16'h8000);
                    s.depth = dbf_pkg::DEPTH_W'($urandom_range(0, 32'h7FFFFFFF));
                    s.last = (i == LONG_PIXEL - 1);
                    send_sample(s, 1'b0, none);
                    pause_after();
                end
            end else begin
                nr = dbf_pkg::BAND_W'($urandom_range(0, 32'h100000));
                fr = $urandom_range(0, 1) ? '0 :
                     dbf_pkg::BAND_W'(nr + $urandom_range(0, 32'h80000));
                ch = dbf_pkg::CHAN_W'($urandom_range(0, 31));
                case (k)
                    0: begin nr = '0; fr = '0; ch = dbf_pkg::CHAN_RESET; end
                    1: begin nr = '1; fr = '0; ch = dbf_pkg::CHAN_RESET; end
                    3: begin nr = '0; fr = '1; ch = dbf_pkg::CHAN_RESET; end
                    4: begin nr = '1; fr = '1; ch = dbf_pkg::CHAN_RESET; end
                    5: begin nr = 31'h50000; fr = 31'h40000; ch = dbf_pkg::CHAN_RESET; end
                    6: ch = '0;
                    7: ch = 5'h0F;   // no depth test
                    8: ch = 5'h17;   // alpha absent
                    default: ;
                endcase
                apply_band(nr, fr, ch);
                phase_start = sent_items;
                while (sent_items - phase_start < PHASE_ITEMS) send_pixel(pixel_len());
            end
            k++;
        end

        steady = 1'b0;
        settle();
        repeat (4) @(posedge aclk);

        $display("Covered %0d sample requests and %0d flattened pixels over %0d band settings",
                 accepted, results_seen, settings_used);
        $display("Mismatching or unexpected results: %0d", fails);
        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dbf_pkg.sv
rtl/core/deep_depth_band_flatten.sv
bench/tb_deep_depth_band_flatten.sv
